>>> rtl/colsh_pkg.sv
// Shared widths, parameter defaults and command/status codes for the column height set.
`default_nettype none

package colsh_pkg;

  // Parameter defaults
  localparam int DefColumns = 256;
  localparam int DefHeights = 256;

  // Field widths
  localparam int CountW  = 9;
  localparam int ColW    = 8;
  localparam int HeightW = 8;
  localparam int TexW    = 8;

  // Stream payload widths
  localparam int SDataW = 24;
  localparam int MDataW = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED    = 2'd0,
    ST_PRESENT     = 2'd1,
    ST_REMOVED     = 2'd2,
    ST_NOT_PRESENT = 2'd3
  } status_e;

endpackage

`default_nettype wire

>>> rtl/column_sorted_height_set_top.sv
// Per-column sorted height set with per-voxel texture store, one item at a time.
// Each item is loaded, then binary-searched with at most ceil(log2(count+1)) probes
// (a read and a compare each); an insert shifts larger entries up one at a time and
// places the new height, a removal shifts entries down; an out-of-range column or
// height skips the search. Items do not overlap; a stalled result holds the finish step.
// Reset: asynchronous, active low; clears control state and count valid bits only.
`default_nettype none

module column_sorted_height_set_top #(
  parameter int COLUMNS = colsh_pkg::DefColumns,
  parameter int HEIGHTS = colsh_pkg::DefHeights
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [colsh_pkg::SDataW-1:0] s_axis_tdata,  // column, height, texture
  input  wire logic                        s_axis_tuser,  // command
  // result stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [colsh_pkg::MDataW-1:0]      m_axis_tdata,  // count, zero pad
  output logic [1:0]                       m_axis_tuser   // status
);

  import colsh_pkg::*;

  // Addressable columns are limited by the 8-bit column field
  localparam int CntDepth = (COLUMNS < (1 << ColW)) ? COLUMNS : (1 << ColW);
  localparam int CIdxW    = (CntDepth > 1) ? $clog2(CntDepth) : 1;
  localparam int HIdxW    = $clog2(HEIGHTS);
  localparam int MemDepth = CntDepth * HEIGHTS;
  localparam int AddrW    = $clog2(MemDepth);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_LOAD   = 8'b00000010,
    S_SRCH   = 8'b00000100,
    S_CMP    = 8'b00001000,
    S_SHUP   = 8'b00010000,
    S_SHDN   = 8'b00100000,
    S_PUTH   = 8'b01000000,
    S_FINISH = 8'b10000000
  } state_e;

  // Storage
  logic [HeightW-1:0] hl_mem  [MemDepth];
  logic [TexW-1:0]    tex_mem [MemDepth];
  logic [CountW-1:0]  cnt_mem [CntDepth];
  logic [CntDepth-1:0] cnt_vld_q;

  // Control and payload registers
  state_e             state_q, state_d;
  logic               m_valid_q, m_valid_d;
  logic               cmd_q;
  logic [HeightW-1:0] h_q;
  logic [TexW-1:0]    tex_q;
  logic               col_ok_q;
  logic [CIdxW-1:0]   col_idx_q;
  logic [AddrW-1:0]   base_q;
  logic [CountW-1:0]  cnt_rd_q;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [CountW-1:0]  lo_q, lo_d;
  logic [CountW-1:0]  hi_q, hi_d;
  logic [CountW-1:0]  mid_q, mid_d;
  logic [CountW-1:0]  idx_q, idx_d;
  logic               found_q, found_d;
  logic [1:0]         st_q, st_d;
  logic [CountW-1:0]  newcnt_q, newcnt_d;
  logic [1:0]         m_status_q;
  logic [CountW-1:0]  m_count_q;
  logic [HeightW-1:0] rdata_q;

  // Memory access controls
  logic               hl_re, hl_we, tex_we, cnt_we;
  logic [CountW-1:0]  rd_idx, wr_idx;
  logic [HeightW-1:0] wr_data;
  logic [AddrW-1:0]   rd_addr, wr_addr, tex_addr;

  // Input field decode
  logic [ColW-1:0]    in_col;
  logic [HeightW-1:0] in_h;
  logic [TexW-1:0]    in_tex;
  logic [CIdxW-1:0]   in_col_idx;
  logic               s_xfer, m_free;
  logic [CountW-1:0]  cnt_cur;
  logic               h_ok;

  assign in_col     = s_axis_tdata[ColW-1:0];
  assign in_h       = s_axis_tdata[ColW +: HeightW];
  assign in_tex     = s_axis_tdata[ColW+HeightW +: TexW];
  assign in_col_idx = CIdxW'(in_col);

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_free        = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = MDataW'(m_count_q);

  assign cnt_cur = cnt_vld_q[col_idx_q] ? cnt_rd_q : '0;
  assign h_ok    = {1'b0, h_q} < CountW'(HEIGHTS);

  assign rd_addr  = base_q + AddrW'(rd_idx[HIdxW-1:0]);
  assign wr_addr  = base_q + AddrW'(wr_idx[HIdxW-1:0]);
  assign tex_addr = base_q + AddrW'(h_q[HIdxW-1:0]);

  // Sequencer: binary search on the shared compare, then a one-entry-per-cycle shift
  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    cnt_d     = cnt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    idx_d     = idx_q;
    found_d   = found_q;
    st_d      = st_q;
    newcnt_d  = newcnt_q;
    hl_re     = 1'b0;
    hl_we     = 1'b0;
    tex_we    = 1'b0;
    cnt_we    = 1'b0;
    rd_idx    = '0;
    wr_idx    = idx_q;
    wr_data   = rdata_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        found_d = 1'b0;
        if (!col_ok_q) begin
          st_d     = ST_NOT_PRESENT;
          newcnt_d = '0;
          state_d  = S_FINISH;
        end else if (!h_ok) begin
          st_d     = ST_NOT_PRESENT;
          newcnt_d = cnt_cur;
          state_d  = S_FINISH;
        end else begin
          cnt_d   = cnt_cur;
          lo_d    = '0;
          hi_d    = cnt_cur;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          // probe the middle entry
          mid_d   = CountW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
          rd_idx  = mid_d;
          hl_re   = 1'b1;
          state_d = S_CMP;
        end else if (cmd_q == CMD_INSERT) begin
          // lo_q is the count of entries at or below the height
          tex_we = 1'b1;
          if (found_q || cnt_q == CountW'(HEIGHTS)) begin
            st_d     = ST_PRESENT;
            newcnt_d = cnt_q;
            state_d  = S_FINISH;
          end else begin
            st_d     = ST_INSERTED;
            newcnt_d = cnt_q + 1'b1;
            cnt_we   = 1'b1;
            if (cnt_q > lo_q) begin
              rd_idx  = cnt_q - 1'b1;
              hl_re   = 1'b1;
              idx_d   = cnt_q;
              state_d = S_SHUP;
            end else begin
              idx_d   = lo_q;
              state_d = S_PUTH;
            end
          end
        end else begin
          if (found_q) begin
            st_d     = ST_REMOVED;
            newcnt_d = cnt_q - 1'b1;
            cnt_we   = 1'b1;
            idx_d    = lo_q - 1'b1;
            if (lo_q < cnt_q) begin
              rd_idx  = lo_q;
              hl_re   = 1'b1;
              state_d = S_SHDN;
            end else begin
              state_d = S_FINISH;
            end
          end else begin
            st_d     = ST_NOT_PRESENT;
            newcnt_d = cnt_q;
            state_d  = S_FINISH;
          end
        end
      end
      S_CMP: begin
        if (rdata_q <= h_q) begin
          lo_d = mid_q + 1'b1;
          if (rdata_q == h_q) begin
            found_d = 1'b1;
          end
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SRCH;
      end
      S_SHUP: begin
        // move list[idx-1] up to idx
        hl_we = 1'b1;
        if (idx_q - 1'b1 > lo_q) begin
          rd_idx = idx_q - 2'd2;
          hl_re  = 1'b1;
          idx_d  = idx_q - 1'b1;
        end else begin
          idx_d   = lo_q;
          state_d = S_PUTH;
        end
      end
      S_SHDN: begin
        // move list[idx+1] down to idx
        hl_we = 1'b1;
        if ({1'b0, idx_q} + 10'd2 < {1'b0, cnt_q}) begin
          rd_idx = idx_q + 2'd2;
          hl_re  = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_PUTH: begin
        hl_we   = 1'b1;
        wr_data = h_q;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (m_free) begin
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      cnt_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cnt_we) begin
        cnt_vld_q[col_idx_q] <= 1'b1;
      end
    end
  end

  // Item payload and working registers
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      cmd_q     <= s_axis_tuser;
      h_q       <= in_h;
      tex_q     <= in_tex;
      col_ok_q  <= {9'd0, in_col} < 17'(COLUMNS);
      col_idx_q <= in_col_idx;
      base_q    <= AddrW'(in_col_idx) * AddrW'(HEIGHTS);
    end
    cnt_q    <= cnt_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    idx_q    <= idx_d;
    found_q  <= found_d;
    st_q     <= st_d;
    newcnt_q <= newcnt_d;
    if (state_q == S_FINISH && m_free) begin
      m_status_q <= st_q;
      m_count_q  <= newcnt_q;
    end
  end

  // Column count store
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      cnt_rd_q <= cnt_mem[in_col_idx];
    end
    if (cnt_we) begin
      cnt_mem[col_idx_q] <= newcnt_d;
    end
  end

  // Height list store: one read and one write port
  always_ff @(posedge clk_i) begin
    if (hl_re) begin
      rdata_q <= hl_mem[rd_addr];
    end
    if (hl_we) begin
      hl_mem[wr_addr] <= wr_data;
    end
  end

  // Voxel texture store, write only
  always_ff @(posedge clk_i) begin
    if (tex_we) begin
      tex_mem[tex_addr] <= tex_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/colsh_checker.sv
// Port-level checks for the column height set, bound to the top level.
`default_nettype none

module colsh_checker #(
  parameter int HEIGHTS = colsh_pkg::DefHeights
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic [colsh_pkg::SDataW-1:0] s_axis_tdata,
  input wire logic                         s_axis_tuser,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [colsh_pkg::MDataW-1:0] m_axis_tdata,
  input wire logic [1:0]                   m_axis_tuser
);

  import colsh_pkg::*;

  // One item in flight: no transfer right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // Waiting input holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && !s_axis_tready) |=>
      (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser)))
    else $error("input changed while waiting");

  // Count never exceeds the list depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[CountW-1:0] <= CountW'(HEIGHTS)))
    else $error("count above list depth");

  // A fresh insert leaves a non-empty column; a removal leaves room
  a_status_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser != ST_INSERTED || m_axis_tdata[CountW-1:0] != '0) &&
       (m_axis_tuser != ST_REMOVED  || m_axis_tdata[CountW-1:0] < CountW'(HEIGHTS))))
    else $error("status and count disagree");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind column_sorted_height_set_top colsh_checker #(.HEIGHTS(HEIGHTS)) u_colsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
